@@ rtl/rsmd_pkg.sv @@
package rsmd_pkg;

	// word width and pipeline shape
	localparam int unsigned DataW     = 32;
	localparam int unsigned DivSteps  = DataW;
	// front stages (3) + divider steps + output register
	localparam int unsigned PipeDepth = DivSteps + 4;

	localparam logic [DataW-1:0] QMax = {1'b0, {(DataW-1){1'b1}}};
	localparam logic [DataW-1:0] QMin = {1'b1, {(DataW-1){1'b0}}};

	// one word in flight through the divider: partial remainder, dividend bits
	// shifting out while quotient bits shift in, divisor magnitude, sign, saturate
	typedef struct packed {
		logic [DataW-1:0] rem;
		logic [DataW-1:0] acc;
		logic [DataW-1:0] den;
		logic             neg;
		logic             sat;
	} div_item_t;

endpackage

@@ rtl/rsmd_div.sv @@
module rsmd_div
	import rsmd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output div_item_t out_item
);

	// one restoring step: bring down the next dividend bit, subtract if it fits
	function automatic div_item_t div_step(div_item_t x);
		div_item_t      y;
		logic [DataW:0] part;
		logic [DataW:0] diff;
		logic           take;
		part  = {x.rem, x.acc[DataW-1]};
		diff  = part - {1'b0, x.den};
		take  = (part >= {1'b0, x.den});
		y     = x;
		y.rem = take ? diff[DataW-1:0] : part[DataW-1:0];
		y.acc = {x.acc[DataW-2:0], take};
		return y;
	endfunction

	div_item_t             item_s [DivSteps];
	div_item_t             src    [DivSteps];
	logic [DivSteps-1:0]   valid_s;
	logic [DivSteps-1:0]   src_valid;
	logic [DivSteps:0]     rdy;

	// a stage takes a new word when it is empty or its word moves on
	assign rdy[DivSteps] = out_ready;

	for (genvar i = 0; i < DivSteps; i++) begin : g_step
		if (i == 0) begin : g_first
			assign src[i]       = div_step(in_item);
			assign src_valid[i] = in_valid;
		end else begin : g_next
			assign src[i]       = div_step(item_s[i-1]);
			assign src_valid[i] = valid_s[i-1];
		end

		assign rdy[i] = !valid_s[i] || rdy[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				valid_s[i] <= src_valid[i];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && src_valid[i]) begin
				item_s[i] <= src[i];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = valid_s[DivSteps-1];
	assign out_item  = item_s[DivSteps-1];

endmodule

@@ rtl/rounded_saturating_muldiv.sv @@
// Channel   Words                               Handshake
// input     multiplicand, multiplier, divisor   in_valid / in_ready
// output    quotient                            out_valid / out_ready
//
// One word per cycle sustained while out_ready stays high; registered stages in order: magnitudes,
// 32x32 multiply, round-add and range check, 32 restoring divide steps, sign and saturate.
// The divider computes one quotient bit per stage.
// arst_n clears all valid bits; data registers are not reset.
// Any stage with an empty slot takes a word, so bubbles close up under a stall.
module rounded_saturating_muldiv
	import rsmd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [DataW-1:0] multiplicand,
	input  logic signed [DataW-1:0] multiplier,
	input  logic signed [DataW-1:0] divisor,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [DataW-1:0] quotient
);

	localparam int unsigned ProdW = 2*DataW - 1;

	// stage 1: magnitudes and result sign
	logic [DataW-1:0] am_s1, bm_s1, dm_s1;
	logic             neg_s1, dz_s1, valid_s1;
	// stage 2: product
	logic [ProdW-1:0] prod_s2;
	logic [DataW-1:0] dm_s2;
	logic             neg_s2, dz_s2, valid_s2;
	// stage 3: rounded dividend, ready for the divider
	div_item_t        item_s3;
	logic             valid_s3;
	// output register
	logic [DataW-1:0] quotient_q;
	logic             out_valid_q;

	logic             rdy1, rdy2, rdy3, rdy_out;
	logic             div_in_ready, div_out_valid;
	div_item_t        div_out;

	logic [DataW-1:0] am, bm, dm;
	logic             d_neg, d_zero, a_zero, b_zero, neg;
	logic [2*DataW-1:0] prod_full;
	logic [ProdW-1:0] num;
	logic [DataW-2:0] num_hi;
	div_item_t        item_d3;
	logic [DataW-1:0] qmag, qfin;

	// ready chain, back to front
	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy3     = !valid_s3 || div_in_ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	// magnitudes; negating a negative divisor only flips the multiplicand sign
	always_comb begin
		am     = multiplicand[DataW-1] ? (~multiplicand + 1'b1) : multiplicand;
		bm     = multiplier[DataW-1]   ? (~multiplier + 1'b1)   : multiplier;
		dm     = divisor[DataW-1]      ? (~divisor + 1'b1)      : divisor;
		d_neg  = divisor[DataW-1];
		d_zero = (divisor == '0);
		a_zero = (multiplicand == '0);
		b_zero = (multiplier == '0);
		if (d_zero) begin
			neg = multiplicand[DataW-1] ^ multiplier[DataW-1];
		end else begin
			// zero product counts as non-negative
			neg = !a_zero && !b_zero
			      && (multiplicand[DataW-1] ^ d_neg ^ multiplier[DataW-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			am_s1  <= am;
			bm_s1  <= bm;
			dm_s1  <= dm;
			neg_s1 <= neg;
			dz_s1  <= d_zero;
		end
	end

	// unsigned product, at most 2^62
	assign prod_full = (2*DataW)'(am_s1) * (2*DataW)'(bm_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			prod_s2 <= prod_full[ProdW-1:0];
			dm_s2   <= dm_s1;
			neg_s2  <= neg_s1;
			dz_s2   <= dz_s1;
		end
	end

	// round away from zero on the magnitude; quotient >= 2^32 when high half >= divisor
	always_comb begin
		num          = prod_s2 + ProdW'(dm_s2 >> 1);
		num_hi       = num[ProdW-1:DataW];
		item_d3.rem  = {1'b0, num_hi};
		item_d3.acc  = num[DataW-1:0];
		item_d3.den  = dm_s2;
		item_d3.neg  = neg_s2;
		item_d3.sat  = dz_s2 || ({1'b0, num_hi} >= dm_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			item_s3 <= item_d3;
		end
	end

	rsmd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_ready  (div_in_ready),
		.in_item   (item_s3),
		.out_valid (div_out_valid),
		.out_ready (rdy_out),
		.out_item  (div_out)
	);

	// apply sign and clamp to the signed range
	always_comb begin
		qmag = div_out.acc;
		if (div_out.sat) begin
			qfin = div_out.neg ? QMin : QMax;
		end else if (div_out.neg) begin
			qfin = (qmag > QMin) ? QMin : (~qmag + 1'b1);
		end else begin
			qfin = qmag[DataW-1] ? QMax : qmag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && div_out_valid) begin
			quotient_q <= qfin;
		end
	end

	assign out_valid = out_valid_q;
	assign quotient  = quotient_q;

endmodule

@@ rtl/rsmd_chk.sv @@
module rsmd_chk
	import rsmd_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic signed [DataW-1:0] multiplicand,
	input logic signed [DataW-1:0] multiplier,
	input logic signed [DataW-1:0] divisor,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [DataW-1:0] quotient
);

	localparam int unsigned CntW = $clog2(PipeDepth + 1);

	// words accepted but not yet delivered
	logic [CntW-1:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CntW'(in_valid && in_ready)
			              - CntW'(out_valid && out_ready);
		end
	end

	// a stalled input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(multiplicand)
		&& $stable(multiplier) && $stable(divisor))
		else $error("input word changed while stalled");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quotient))
		else $error("result changed while stalled");

	// no result without a word in flight
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result without an accepted word");

	// never more words in flight than pipeline slots
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CntW'(PipeDepth))
		else $error("more words in flight than stages");

	// reset empties the pipeline
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

endmodule

bind rounded_saturating_muldiv rsmd_chk u_rsmd_chk (.*);

@@ tb/sv/rounded_saturating_muldiv_test.sv @@
module rounded_saturating_muldiv_test;
	import rsmd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned StallLimit  = 5000;
	localparam int unsigned RandPerMode = 112;
	localparam int unsigned ReportMax   = 10;

	// 64-bit saturation bounds for the quotient
	localparam longint QHi = 64'sd2147483647;
	localparam longint QLo = -64'sd2147483648;

	typedef enum int unsigned {
		IdleNone,
		IdleSender,
		IdleReceiver,
		IdleBoth
	} idle_mode_t;

	typedef struct {
		logic signed [DataW-1:0] mcand;
		logic signed [DataW-1:0] mplier;
		logic signed [DataW-1:0] dvsr;
	} operands_t;

	typedef struct {
		operands_t               ops;
		logic signed [DataW-1:0] quot;
	} quotient_entry_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    in_valid     = 1'b0;
	logic                    in_ready;
	logic signed [DataW-1:0] multiplicand = '0;
	logic signed [DataW-1:0] multiplier   = '0;
	logic signed [DataW-1:0] divisor      = '0;
	logic                    out_valid;
	logic                    out_ready    = 1'b1;
	logic signed [DataW-1:0] quotient;

	operands_t       pending_words[$];
	quotient_entry_t expected_quotients[$];

	idle_mode_t  idle_mode    = IdleNone;
	logic        in_took      = 1'b0;
	int unsigned words_in     = 0;
	int unsigned words_out    = 0;
	int unsigned saturated    = 0;
	int unsigned zero_divides = 0;
	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;

	rounded_saturating_muldiv u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.multiplicand (multiplicand),
		.multiplier   (multiplier),
		.divisor      (divisor),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.quotient     (quotient)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// rounded, saturated product over divisor, exact at 64 bits
	function automatic logic signed [DataW-1:0] rounded_quotient(
		input logic signed [DataW-1:0] mcand,
		input logic signed [DataW-1:0] mplier,
		input logic signed [DataW-1:0] dvsr
	);
		longint a;
		longint b;
		longint d;
		longint prod;
		longint q;
		a = mcand;
		b = mplier;
		d = dvsr;
		// divide by zero: sign from the factor sign bits
		if (d == 0)
			return (mcand[DataW-1] != mplier[DataW-1]) ? QMin : QMax;
		if (d < 0) begin
			a = -a;
			d = -d;
		end
		prod = a * b;
		// half away from zero; a zero product takes the non-negative path
		if (prod >= 0)
			prod = prod + d / 2;
		else
			prod = prod - d / 2;
		q = prod / d;
		if (q > QHi)
			q = QHi;
		if (q < QLo)
			q = QLo;
		return q[DataW-1:0];
	endfunction

	function automatic bit roll(input int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// operand mix: corners, small, medium, full range
	function automatic logic signed [DataW-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return QMin;
					1: return QMax;
					2: return '0;
					3: return 1;
					default: return -1;
				endcase
			end
			1, 2: return $signed($urandom_range(0, 32)) - 16;
			3: return $signed($urandom_range(0, 131072)) - 65536;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_word(
		input logic signed [DataW-1:0] mcand,
		input logic signed [DataW-1:0] mplier,
		input logic signed [DataW-1:0] dvsr
	);
		operands_t w;
		w.mcand  = mcand;
		w.mplier = mplier;
		w.dvsr   = dvsr;
		pending_words.push_back(w);
	endtask

	task automatic note_mismatch(input string msg);
		if (mismatches < ReportMax)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || expected_quotients.size() != 0)
			@(posedge clk);
	endtask

	task automatic entry_leftover();
		quotient_entry_t entry;
		entry = expected_quotients.pop_front();
		note_mismatch($sformatf("missing quotient for %0d * %0d / %0d (expected %0d)",
			entry.ops.mcand, entry.ops.mplier, entry.ops.dvsr, entry.quot));
	endtask

	// random words with a share of exact rounding ties and near-unity ratios
	task automatic push_random_words(input int unsigned count);
		logic signed [DataW-1:0] a;
		logic signed [DataW-1:0] b;
		logic signed [DataW-1:0] d;
		int                      k;
		for (int unsigned i = 0; i < count; i++) begin
			case ($urandom_range(0, 7))
				0: begin
					// product lands exactly halfway between two quotients
					d = 2 * $urandom_range(1, 1000);
					k = $signed($urandom_range(0, 2000)) - 1000;
					b = roll(50) ? 1 : -1;
					a = k * d + ((k < 0) ? -(d / 2) : d / 2);
					if (roll(50))
						d = -d;
				end
				1: begin
					a = pick_operand();
					b = pick_operand();
					d = roll(50) ? a : -a;
				end
				default: begin
					a = pick_operand();
					b = pick_operand();
					d = roll(5) ? '0 : pick_operand();
				end
			endcase
			push_word(a, b, d);
		end
	endtask

	// driver: new word on the falling edge once the last one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (pending_words.size() != 0 &&
				    !roll(idle_mode == IdleSender ? 82 : idle_mode == IdleBoth ? 20 : 0)) begin
					multiplicand <= pending_words[0].mcand;
					multiplier   <= pending_words[0].mplier;
					divisor      <= pending_words[0].dvsr;
					in_valid     <= 1'b1;
					pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !roll(idle_mode == IdleReceiver ? 82 : idle_mode == IdleBoth ? 20 : 0);
		end
	end

	// monitor: predict on input handshake, check on output handshake
	always @(posedge clk or negedge arst_n) begin : monitor_b
		quotient_entry_t entry;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				entry.ops.mcand  = multiplicand;
				entry.ops.mplier = multiplier;
				entry.ops.dvsr   = divisor;
				entry.quot       = rounded_quotient(multiplicand, multiplier, divisor);
				expected_quotients.push_back(entry);
				words_in++;
				if (divisor == 0)
					zero_divides++;
				if (entry.quot == QMax || entry.quot == QMin)
					saturated++;
			end
			if (out_valid && out_ready) begin
				words_out++;
				if (expected_quotients.size() == 0) begin
					note_mismatch($sformatf("unexpected quotient %0d", quotient));
				end else begin
					entry = expected_quotients.pop_front();
					if (quotient !== entry.quot)
						note_mismatch($sformatf("%0d * %0d / %0d: expected %0d, got %0d",
							entry.ops.mcand, entry.ops.mplier, entry.ops.dvsr,
							entry.quot, quotient));
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("Timeout: no word moved for %0d cycles", StallLimit);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: rounding ties, signs, zero divisor, extremes
		push_word(5, 1, 2);
		push_word(-5, 1, 2);
		push_word(7, 1, -2);
		push_word(1, 1, 3);
		push_word(2, 1, 3);
		push_word(0, 5, -3);
		push_word(0, 0, 7);
		push_word(1, 1, 0);
		push_word(-1, 1, 0);
		push_word(-1, -1, 0);
		push_word(0, -1, 0);
		push_word(QMin, QMin, 0);
		push_word(QMin, -1, -1);
		push_word(QMin, QMin, 1);
		push_word(QMin, QMax, 1);
		push_word(QMax, QMax, QMin);
		push_word(QMin, 1, QMin);
		push_word(1, 1, QMin);
		push_word(QMax, QMax, QMax);
		push_word(QMin, QMin, QMin);
		push_word(QMax, 1, 1);
		push_word(QMax, -1, 1);
		push_word(QMax, QMax, -1);
		push_word(32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F);
		wait_drained();

		// random words under each idling mode
		for (int m = IdleNone; m <= IdleBoth; m++) begin
			idle_mode = idle_mode_t'(m);
			push_random_words(RandPerMode);
			wait_drained();
		end
		idle_mode = IdleNone;

		// catch stray words after the pipeline should be empty
		repeat (PipeDepth + 8) @(posedge clk);
		while (expected_quotients.size() != 0) begin
			entry_leftover();
		end

		$display("Sent %0d words and checked %0d quotients under four idling modes",
			words_in, words_out);
		$display("%0d zero divisors, %0d saturated results, %0d mismatches",
			zero_divides, saturated, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/rsmd_pkg.sv
rtl/rsmd_div.sv
rtl/rounded_saturating_muldiv.sv
rtl/rsmd_chk.sv
tb/sv/rounded_saturating_muldiv_test.sv
